/* hdl/bsc_pkg.sv */
`default_nettype none

package bsc_pkg;

  // Tile and pixel geometry.
  localparam int TILE_SIDE   = 32;
  localparam int TILE_LOG2   = $clog2(TILE_SIDE);
  localparam int PIXEL_BYTES = 4;
  localparam int PIX_LOG2    = $clog2(PIXEL_BYTES);

  // Field and register widths.
  localparam int CFG_W     = 13;
  localparam int IDX_W     = 14;
  localparam int OFF_W     = 27;
  localparam int BCNT_W    = 8;
  localparam int SLOT_W    = 7;
  localparam int GRID_W    = CFG_W - TILE_LOG2;
  localparam int CNT_W     = 2 * GRID_W;
  localparam int ROW_W     = $clog2(TILE_SIDE + 1);
  localparam int PROD_W    = 2 * CFG_W;
  localparam int DIV_CNT_W = $clog2(IDX_W);
  localparam int REG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE           = 3'd0,
    REG_IMAGE_WIDTH    = 3'd1,
    REG_IMAGE_HEIGHT   = 3'd2,
    REG_CONTENT_WIDTH  = 3'd3,
    REG_CONTENT_HEIGHT = 3'd4,
    REG_START_ROW      = 3'd5
  } reg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_entry;
    logic calc_count;
    logic div_start;
    logic geom;
    logic sizes;
    logic bases;
    logic src_row;
    logic dst_row;
    logic emit;
    logic emit_bad;
    logic advance;
  } bsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;
    logic count_zero;
    logic div_done;
    logic no_rows;
    logic last_row;
  } bsc_sts_t;

endpackage

`default_nettype wire

/* hdl/bsc_in_if.sv */
`default_nettype none

interface bsc_in_if;
  logic                      valid;
  logic                      ready;
  logic [bsc_pkg::IDX_W-1:0] tile_index;

  modport source (output valid, output tile_index, input ready);
  modport sink (input valid, input tile_index, output ready);
endinterface

`default_nettype wire

/* hdl/bsc_out_if.sv */
`default_nettype none

interface bsc_out_if;
  logic                       valid;
  logic                       ready;
  logic [bsc_pkg::OFF_W-1:0]  src_offset;
  logic [bsc_pkg::OFF_W-1:0]  dst_offset;
  logic [bsc_pkg::BCNT_W-1:0] byte_count;
  logic                       bad_index;
  logic                       last;

  modport source (output valid, output src_offset, output dst_offset, output byte_count,
                  output bad_index, output last, input ready);
  modport sink (input valid, input src_offset, input dst_offset, input byte_count,
                input bad_index, input last, output ready);
endinterface

`default_nettype wire

/* hdl/bsc_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module bsc_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [bsc_pkg::IDX_W-1:0]  dividend_i,
  input  wire logic [bsc_pkg::GRID_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [bsc_pkg::IDX_W-1:0]       quotient_o,
  output logic [bsc_pkg::GRID_W-1:0]      remainder_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [bsc_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [bsc_pkg::IDX_W-1:0]        num_q;
  logic [bsc_pkg::GRID_W-1:0]       den_q;
  logic [bsc_pkg::GRID_W-1:0]       rem_q;
  logic [bsc_pkg::GRID_W:0]         trial;
  logic [bsc_pkg::GRID_W:0]         diff;
  logic                             ge;
  logic [bsc_pkg::GRID_W-1:0]       rem_d;

  always_comb begin
    trial = {rem_q, num_q[bsc_pkg::IDX_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? diff[bsc_pkg::GRID_W-1:0] : trial[bsc_pkg::GRID_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + bsc_pkg::DIV_CNT_W'(1);
        if (cnt_q == bsc_pkg::DIV_CNT_W'(bsc_pkg::IDX_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[bsc_pkg::IDX_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = num_q;
  assign remainder_o = rem_q;

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

/* hdl/bsc_datapath.sv */
`default_nettype none

// Configuration registers, slot counter, divider, shared multiplier and
// the offset accumulators that feed the result register.
module bsc_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bsc_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bsc_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic [bsc_pkg::IDX_W-1:0]      tile_index_i,
  input  wire bsc_pkg::bsc_cmd_t              cmd_i,
  output bsc_pkg::bsc_sts_t                   sts_o,
  output logic [bsc_pkg::OFF_W-1:0]           src_offset_o,
  output logic [bsc_pkg::OFF_W-1:0]           dst_offset_o,
  output logic [bsc_pkg::BCNT_W-1:0]          byte_count_o,
  output logic                                bad_index_o,
  output logic                                last_o
);

  // Configuration and slot state.
  logic                           mode_q;
  logic [bsc_pkg::CFG_W-1:0]      iw_q, ih_q, cw_q, ch_q, sr_q;
  logic [bsc_pkg::SLOT_W-1:0]     slot_x_q, slot_y_q;
  logic [bsc_pkg::SLOT_W-1:0]     slot_x_d, slot_y_d;
  logic [bsc_pkg::SLOT_W-1:0]     slot_x_inc, slot_y_inc;
  logic [bsc_pkg::GRID_W-1:0]     bx, by;

  // Per-item working registers.
  logic [bsc_pkg::IDX_W-1:0]      entry_q;
  logic [bsc_pkg::CNT_W-1:0]      count_q;
  logic [bsc_pkg::CFG_W-1:0]      sx_q, sy_q, dx_q, dy_q, lim_q;
  logic [bsc_pkg::CFG_W-1:0]      sx_d, sy_d, dx_d, dy_d, lim_d;
  logic [bsc_pkg::ROW_W-1:0]      w_q, rows_q, rows_left_q;
  logic [bsc_pkg::ROW_W-1:0]      w_d, h_d, rows_d;
  logic [bsc_pkg::PROD_W-1:0]     prod_q, prod_d;
  logic [bsc_pkg::CFG_W-1:0]      mul_a;
  logic [bsc_pkg::OFF_W-1:0]      src_q, dst_q;
  logic [bsc_pkg::OFF_W-1:0]      prod_bytes, src_add, dst_add, row_step;

  // Result register.
  logic [bsc_pkg::OFF_W-1:0]      out_src_q, out_dst_q;
  logic [bsc_pkg::BCNT_W-1:0]     out_bc_q;
  logic                           out_bad_q, out_last_q;

  // Divider.
  logic                           div_done;
  logic [bsc_pkg::IDX_W-1:0]      div_quo;
  logic [bsc_pkg::GRID_W-1:0]     div_rem;
  logic [bsc_pkg::CFG_W-1:0]      ex_px, ey_px, slot_x_px, slot_y_px;
  logic [bsc_pkg::CFG_W:0]        sx_end, sy_end;
  logic [bsc_pkg::CFG_W-1:0]      avail;

  assign bx = cw_q[bsc_pkg::CFG_W-1:bsc_pkg::TILE_LOG2];
  assign by = ch_q[bsc_pkg::CFG_W-1:bsc_pkg::TILE_LOG2];

  bsc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (entry_q),
    .divisor_i   (bx),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Slot advance in raster order with wrap to zero.
  always_comb begin
    slot_x_inc = slot_x_q + bsc_pkg::SLOT_W'(1);
    slot_y_inc = slot_y_q + bsc_pkg::SLOT_W'(1);
    slot_x_d   = slot_x_inc;
    slot_y_d   = slot_y_q;
    if (bsc_pkg::GRID_W'(slot_x_inc) >= bx) begin
      slot_x_d = '0;
      slot_y_d = (bsc_pkg::GRID_W'(slot_y_inc) >= by) ? '0 : slot_y_inc;
    end
  end

  // Tile corners in pixels; the entry and the slot swap roles with the mode.
  always_comb begin
    ex_px     = bsc_pkg::CFG_W'(div_rem) << bsc_pkg::TILE_LOG2;
    ey_px     = bsc_pkg::CFG_W'(div_quo[bsc_pkg::GRID_W-1:0]) << bsc_pkg::TILE_LOG2;
    slot_x_px = bsc_pkg::CFG_W'(slot_x_q) << bsc_pkg::TILE_LOG2;
    slot_y_px = bsc_pkg::CFG_W'(slot_y_q) << bsc_pkg::TILE_LOG2;
    if (mode_q) begin
      sx_d  = slot_x_px;
      sy_d  = slot_y_px;
      dx_d  = ex_px;
      dy_d  = ey_px;
      lim_d = ch_q;
    end else begin
      sx_d  = ex_px;
      sy_d  = ey_px;
      dx_d  = slot_x_px;
      dy_d  = slot_y_px;
      lim_d = ih_q;
    end
  end

  // Clipped tile width and number of rows to emit.
  always_comb begin
    sx_end = {1'b0, sx_q} + (bsc_pkg::CFG_W + 1)'(bsc_pkg::TILE_SIDE);
    sy_end = {1'b0, sy_q} + (bsc_pkg::CFG_W + 1)'(bsc_pkg::TILE_SIDE);
    avail  = lim_q - dy_q;

    if (sx_q >= iw_q) begin
      w_d = '0;
    end else if (sx_end > {1'b0, iw_q}) begin
      w_d = bsc_pkg::ROW_W'(iw_q - sx_q);
    end else begin
      w_d = bsc_pkg::ROW_W'(bsc_pkg::TILE_SIDE);
    end

    if (sy_q >= lim_q) begin
      h_d = '0;
    end else if (sy_end > {1'b0, lim_q}) begin
      h_d = bsc_pkg::ROW_W'(lim_q - sy_q);
    end else begin
      h_d = bsc_pkg::ROW_W'(bsc_pkg::TILE_SIDE);
    end

    // When unscrambling, rows past the content height are dropped, which
    // only ever trims the tail of the tile.
    if (dy_q >= lim_q) begin
      rows_d = '0;
    end else if (mode_q && (avail < bsc_pkg::CFG_W'(h_d))) begin
      rows_d = bsc_pkg::ROW_W'(avail);
    end else begin
      rows_d = h_d;
    end
  end

  // One shared multiplier against the image width.
  always_comb begin
    if (cmd_i.sizes) begin
      mul_a = sr_q;
    end else if (cmd_i.bases) begin
      mul_a = sy_q;
    end else begin
      mul_a = dy_q;
    end
    prod_d = bsc_pkg::PROD_W'(mul_a) * bsc_pkg::PROD_W'(iw_q);
  end

  always_comb begin
    prod_bytes = bsc_pkg::OFF_W'(prod_q) << bsc_pkg::PIX_LOG2;
    src_add    = (bsc_pkg::OFF_W'(prod_q) + bsc_pkg::OFF_W'(sx_q)) << bsc_pkg::PIX_LOG2;
    dst_add    = (bsc_pkg::OFF_W'(prod_q) + bsc_pkg::OFF_W'(dx_q)) << bsc_pkg::PIX_LOG2;
    row_step   = bsc_pkg::OFF_W'(iw_q) << bsc_pkg::PIX_LOG2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      iw_q     <= bsc_pkg::CFG_W'(1);
      ih_q     <= bsc_pkg::CFG_W'(1);
      cw_q     <= '0;
      ch_q     <= '0;
      sr_q     <= '0;
      slot_x_q <= '0;
      slot_y_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          bsc_pkg::REG_MODE:           mode_q <= cfg_data_i[0];
          bsc_pkg::REG_IMAGE_WIDTH:    iw_q   <= cfg_data_i;
          bsc_pkg::REG_IMAGE_HEIGHT:   ih_q   <= cfg_data_i;
          bsc_pkg::REG_CONTENT_WIDTH:  cw_q   <= cfg_data_i;
          bsc_pkg::REG_CONTENT_HEIGHT: ch_q   <= cfg_data_i;
          bsc_pkg::REG_START_ROW:      sr_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.advance) begin
        slot_x_q <= slot_x_d;
        slot_y_q <= slot_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_entry) begin
      entry_q <= tile_index_i;
    end
    if (cmd_i.calc_count) begin
      count_q <= bsc_pkg::CNT_W'(bx) * bsc_pkg::CNT_W'(by);
    end
    if (cmd_i.geom) begin
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      lim_q <= lim_d;
    end
    if (cmd_i.sizes || cmd_i.bases || cmd_i.src_row) begin
      prod_q <= prod_d;
    end
    if (cmd_i.sizes) begin
      w_q    <= w_d;
      rows_q <= rows_d;
    end
    if (cmd_i.bases) begin
      src_q <= mode_q ? prod_bytes : '0;
      dst_q <= mode_q ? '0 : prod_bytes;
    end
    if (cmd_i.src_row) begin
      src_q <= src_q + src_add;
    end
    if (cmd_i.dst_row) begin
      dst_q       <= dst_q + dst_add;
      rows_left_q <= rows_q;
    end
    if (cmd_i.emit) begin
      src_q       <= src_q + row_step;
      dst_q       <= dst_q + row_step;
      rows_left_q <= rows_left_q - bsc_pkg::ROW_W'(1);
      out_src_q   <= src_q;
      out_dst_q   <= dst_q;
      out_bc_q    <= bsc_pkg::BCNT_W'(w_q) << bsc_pkg::PIX_LOG2;
      out_bad_q   <= 1'b0;
      out_last_q  <= (rows_left_q == bsc_pkg::ROW_W'(1));
    end
    if (cmd_i.emit_bad) begin
      out_src_q  <= '0;
      out_dst_q  <= '0;
      out_bc_q   <= '0;
      out_bad_q  <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  always_comb begin
    sts_o.bad        = (bsc_pkg::CNT_W'(entry_q) >= count_q);
    sts_o.count_zero = (count_q == '0);
    sts_o.div_done   = div_done;
    sts_o.no_rows    = (rows_q == '0);
    sts_o.last_row   = (rows_left_q == bsc_pkg::ROW_W'(1));
  end

  assign src_offset_o = out_src_q;
  assign dst_offset_o = out_dst_q;
  assign byte_count_o = out_bc_q;
  assign bad_index_o  = out_bad_q;
  assign last_o       = out_last_q;

`ifndef SYNTHESIS
  a_bad_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_bad |=> (out_bad_q && out_last_q && (out_src_q == '0) && (out_dst_q == '0)))
    else $error("bad entry result carries nonzero offsets");
  a_slot_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |=> (bsc_pkg::GRID_W'(slot_x_q) < bx))
    else $error("slot column left the tile grid after advance");
`endif

endmodule

`default_nettype wire

/* hdl/bsc_ctrl.sv */
`default_nettype none

// Sequencer: walks one request through count, divide, geometry, offsets
// and row emission, and owns the valid flag of the result register.
module bsc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire bsc_pkg::bsc_sts_t sts_i,
  output bsc_pkg::bsc_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COUNT,
    S_CHECK,
    S_DIV,
    S_GEOM,
    S_SIZES,
    S_BASES,
    S_SRC_ROW,
    S_DST_ROW,
    S_EMIT,
    S_EMIT_BAD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_free    = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_entry = 1'b1;
          state_d          = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd_o.calc_count = 1'b1;
        state_d          = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.bad) begin
          state_d = S_EMIT_BAD;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_GEOM;
        end
      end
      S_GEOM: begin
        cmd_o.geom    = 1'b1;
        cmd_o.advance = 1'b1;
        state_d       = S_SIZES;
      end
      S_SIZES: begin
        cmd_o.sizes = 1'b1;
        state_d     = S_BASES;
      end
      S_BASES: begin
        cmd_o.bases = 1'b1;
        state_d     = S_SRC_ROW;
      end
      S_SRC_ROW: begin
        cmd_o.src_row = 1'b1;
        state_d       = S_DST_ROW;
      end
      S_DST_ROW: begin
        cmd_o.dst_row = 1'b1;
        state_d       = sts_i.no_rows ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.last_row) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT_BAD: begin
        if (out_free) begin
          cmd_o.emit_bad = 1'b1;
          cmd_o.advance  = !sts_i.count_zero;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sts_i.div_done) |-> (state_q == S_DIV))
    else $error("divider finished while the sequencer was not waiting");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit || cmd_o.emit_bad) |-> (!out_valid_q || out_ready_i))
    else $error("result register loaded over an untaken result");
`endif

endmodule

`default_nettype wire

/* hdl/block_shuffle_copy_address_gen_unit.sv */
// Row-copy address generator for tile shuffling of an RGBA image.
// Input channel in_i carries one shuffle-map entry (tile_index) per request.
// Output channel out_o carries row-copy descriptors: source and destination
// byte offsets and a byte count, with last set on the final descriptor of a
// request and bad_index set on the single descriptor of an out-of-range entry.
// Both channels use a valid/ready handshake; a request or a descriptor moves
// on a rising edge where both are high. Registers are written through
// cfg_we_i / cfg_index_i / cfg_data_i; the user must write them only while
// the block is idle, which the block itself does not enforce.
// One request is worked on at a time. A valid entry goes through setup
// (a bit-serial divider that splits the entry into tile x and y, then steps
// on the shared width multiplier), then emits one descriptor per row, up to
// 32 rows. An out-of-range entry gets its single descriptor and no divide.
// A stalled receiver holds the output register and the row sequencer waits;
// the next request is taken as soon as the last descriptor is registered.
// Reset clears the slot counter to zero and the registers to their defaults.
`default_nettype none

module block_shuffle_copy_address_gen_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bsc_pkg::REG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bsc_pkg::CFG_W-1:0]      cfg_data_i,
  bsc_in_if.sink                              in_i,
  bsc_out_if.source                           out_o
);

  bsc_pkg::bsc_cmd_t cmd;
  bsc_pkg::bsc_sts_t sts;
  logic              in_ready;
  logic              out_valid;

  // The sequencer issues one command set per cycle and reacts to status.
  bsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the registers, slot counter and result payload.
  bsc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .tile_index_i (in_i.tile_index),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .src_offset_o (out_o.src_offset),
    .dst_offset_o (out_o.dst_offset),
    .byte_count_o (out_o.byte_count),
    .bad_index_o  (out_o.bad_index),
    .last_o       (out_o.last)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

`default_nettype wire
